// ----- src/wsd_pkg.sv -----
// shared types, constants and ring helpers for the work-stealing deque block
package wsd_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int DEQUE_DEPTH = 1024;
    localparam int OUT_MAX     = 16384;

    localparam int WID_W  = 4;                       // worker id field width
    localparam int IDX_W  = $clog2(DEQUE_DEPTH);     // slot index width
    localparam int ADDR_W = WID_W + IDX_W;           // task store address width
    localparam int CFG_W  = 5;
    localparam int CNT_W  = 15;
    localparam int TASK_W = 32;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_TAKE  = 2'd1,
        OP_DONE  = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_BADID = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PTR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0] head;
        logic [IDX_W-1:0] tail;
    } ptr_t;

    typedef struct packed {
        logic             en;
        logic [WID_W-1:0] addr_a;
        logic [WID_W-1:0] addr_b;
    } ptr_rd_t;

    typedef struct packed {
        logic             en;
        logic [WID_W-1:0] addr;
        ptr_t             data;
    } ptr_wr_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        if (int'(i) + 1 >= DEQUE_DEPTH) begin
            return '0;
        end
        return IDX_W'(int'(i) + 1);
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
        if (i == '0) begin
            return IDX_W'(DEQUE_DEPTH - 1);
        end
        return IDX_W'(int'(i) - 1);
    endfunction

endpackage

// ----- src/work_stealing_task_deques.sv -----
// top level: per-worker task deques with push, local pop and tail stealing
//
// One circular deque of 32-bit task handles per worker, each of 1024 slots
// holding up to 1023 handles, kept in a 16384-entry task ram addressed by
// {worker, slot}; head and tail pointers live in a small pointer ram with
// valid bits, so nothing needs a clearing pass after reset. After acceptance an
// item first reads the pointers (S_PTR), decides and writes back pointers,
// handle and count, and then in S_DONE loads the result once the output is
// free (a take reads its handle in the S_PTR step). The pointer read and
// write-back of one item thus sets the pace, and a new beat is accepted in the
// cycle its predecessor's result is loaded, so only one item is in flight at a
// time. active_workers (cfg_we/cfg_wdata, reset 1, 0 acts as 1) is to be
// written by the user only while idle; the block does not enforce this.
module work_stealing_task_deques
    import wsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    // request beats
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [WID_W-1:0]  s_worker,
    input  logic [WID_W-1:0]  s_victim,
    input  logic [TASK_W-1:0] s_task_handle,
    // result beats
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic              m_task_valid,
    output logic              m_stolen,
    output logic [TASK_W-1:0] m_task_out,
    output logic [CNT_W-1:0]  m_outstanding
);

    // control
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   out_free;
    logic   out_load;
    logic   ptr_phase;

    // configuration and count
    logic [CFG_W-1:0] cfg_reg;
    logic [CFG_W-1:0] n_workers;
    logic [CNT_W-1:0] pending_reg;
    logic [CNT_W-1:0] pending_next;

    // captured request
    opcode_t           op_reg;
    logic [WID_W-1:0]  wrk_reg;
    logic [WID_W-1:0]  vic_reg;
    logic [TASK_W-1:0] hdl_reg;

    // pointer ram
    ptr_rd_t ptr_rd;
    ptr_wr_t ptr_wr;
    ptr_t    ptr_w;
    ptr_t    ptr_v;

    // task ram
    logic              task_wr_en;
    logic [ADDR_W-1:0] task_wr_addr;
    logic              task_rd_en;
    logic [ADDR_W-1:0] task_rd_addr;
    logic [TASK_W-1:0] task_rdata;

    // decision
    logic    bad_w;
    logic    bad_v;
    logic    w_full;
    logic    w_empty;
    logic    v_empty;
    status_t dec_status;
    logic    dec_tvalid;
    logic    dec_stolen;

    // held result of the decision step
    status_t res_status_reg;
    logic    res_tvalid_reg;
    logic    res_stolen_reg;

    // output register
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [1:0]        m_status_reg;
    logic              m_tvalid_reg;
    logic              m_stolen_reg;
    logic [TASK_W-1:0] m_task_reg;
    logic [CNT_W-1:0]  m_count_reg;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_PTR;
                end
            end
            S_PTR: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                // result goes out; a waiting beat can enter in the same cycle
                if (out_free) begin
                    state_next = s_valid ? S_PTR : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        out_load  = 1'b0;
        ptr_phase = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_PTR: begin
                ptr_phase = 1'b1;
            end
            S_DONE: begin
                s_ready  = out_free;
                out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // configuration: clamp active_workers into 1..MAX_WORKERS
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_W'(1);
        end else if (cfg_we) begin
            cfg_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (cfg_reg == '0) begin
            n_workers = CFG_W'(1);
        end else if (int'(cfg_reg) > MAX_WORKERS) begin
            n_workers = CFG_W'(MAX_WORKERS);
        end else begin
            n_workers = cfg_reg;
        end
    end

    // ---------------------------------------------------------------
    // request capture and pointer read issue
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= opcode_t'(s_opcode);
            wrk_reg <= s_worker;
            vic_reg <= s_victim;
            hdl_reg <= s_task_handle;
        end
    end

    // both pointer pairs are fetched up front, the victim's only matters
    // when the own deque turns out empty
    assign ptr_rd.en     = accept;
    assign ptr_rd.addr_a = s_worker;
    assign ptr_rd.addr_b = s_victim;

    wsd_ptr_ram u_ptr_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_req  (ptr_rd),
        .wr_req  (ptr_wr),
        .rd_a    (ptr_w),
        .rd_b    (ptr_v)
    );

    wsd_task_ram #(
        .DATA_W (TASK_W),
        .ADDR_W (ADDR_W)
    ) u_task_ram (
        .aclk    (aclk),
        .wr_en   (task_wr_en),
        .wr_addr (task_wr_addr),
        .wr_data (hdl_reg),
        .rd_en   (task_rd_en),
        .rd_addr (task_rd_addr),
        .rd_data (task_rdata)
    );

    // ---------------------------------------------------------------
    // decision and write-back, in the step after the pointer read
    // ---------------------------------------------------------------
    assign bad_w   = CFG_W'(wrk_reg) >= n_workers;
    assign bad_v   = CFG_W'(vic_reg) >= n_workers;
    assign w_full  = ring_next(ptr_w.head) == ptr_w.tail;
    assign w_empty = ptr_w.head == ptr_w.tail;
    assign v_empty = ptr_v.head == ptr_v.tail;

    always_comb begin
        dec_status   = STAT_OK;
        dec_tvalid   = 1'b0;
        dec_stolen   = 1'b0;
        ptr_wr.en    = 1'b0;
        ptr_wr.addr  = wrk_reg;
        ptr_wr.data  = ptr_w;
        task_wr_en   = 1'b0;
        task_wr_addr = {wrk_reg, ptr_w.head};
        task_rd_en   = 1'b0;
        task_rd_addr = {wrk_reg, ring_prev(ptr_w.head)};
        pending_next = pending_reg;
        if (ptr_phase) begin
            case (op_reg)
                OP_PUSH: begin
                    if (bad_w) begin
                        dec_status = STAT_BADID;
                    end else if (w_full) begin
                        dec_status = STAT_FULL;
                    end else begin
                        task_wr_en       = 1'b1;
                        ptr_wr.en        = 1'b1;
                        ptr_wr.data.head = ring_next(ptr_w.head);
                        if (pending_reg < CNT_W'(OUT_MAX)) begin
                            pending_next = pending_reg + CNT_W'(1);
                        end
                    end
                end
                OP_TAKE: begin
                    if (bad_w) begin
                        dec_status = STAT_BADID;
                    end else if (!w_empty) begin
                        // pop the newest handle from the own head
                        task_rd_en       = 1'b1;
                        ptr_wr.en        = 1'b1;
                        ptr_wr.data.head = ring_prev(ptr_w.head);
                        dec_tvalid       = 1'b1;
                    end else if (bad_v) begin
                        dec_status = STAT_BADID;
                    end else if (!v_empty) begin
                        // steal the oldest handle from the victim's tail
                        task_rd_en       = 1'b1;
                        task_rd_addr     = {vic_reg, ptr_v.tail};
                        ptr_wr.en        = 1'b1;
                        ptr_wr.addr      = vic_reg;
                        ptr_wr.data      = ptr_v;
                        ptr_wr.data.tail = ring_next(ptr_v.tail);
                        dec_tvalid       = 1'b1;
                        dec_stolen       = 1'b1;
                    end else begin
                        dec_status = STAT_EMPTY;
                    end
                end
                OP_DONE: begin
                    if (pending_reg != '0) begin
                        pending_next = pending_reg - CNT_W'(1);
                    end
                end
                OP_CLEAR: begin
                    pending_next = '0;
                end
                default: begin
                    pending_next = pending_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ptr_phase) begin
            res_status_reg <= dec_status;
            res_tvalid_reg <= dec_tvalid;
            res_stolen_reg <= dec_stolen;
        end
    end

    // ---------------------------------------------------------------
    // result register; the task ram read data holds until the next take
    // ---------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_tvalid_reg <= res_tvalid_reg;
            m_stolen_reg <= res_stolen_reg;
            m_task_reg   <= res_tvalid_reg ? task_rdata : '0;
            m_count_reg  <= pending_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_task_valid  = m_tvalid_reg;
    assign m_stolen      = m_stolen_reg;
    assign m_task_out    = m_task_reg;
    assign m_outstanding = m_count_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("beat accepted while previous item still in decision step");

    a_task_means_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_task_valid |-> m_status == STAT_OK)
        else $error("returned task with non-ok status");

    a_stolen_has_task: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stolen |-> m_task_valid)
        else $error("stolen flag without a returned task");

    a_no_task_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_task_valid |-> m_task_out == '0)
        else $error("task_out nonzero without a returned task");

endmodule

// ----- src/wsd_task_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module wsd_task_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 14
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/wsd_ptr_ram.sv -----
// head/tail pointer store, two read ports, one write port, per-entry valid bits
module wsd_ptr_ram
    import wsd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  ptr_rd_t rd_req,
    input  ptr_wr_t wr_req,
    output ptr_t    rd_a,
    output ptr_t    rd_b
);

    localparam int DEPTH = 2**WID_W;

    ptr_t             mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    ptr_t             rd_a_reg;
    ptr_t             rd_b_reg;
    logic             rd_a_vld_reg;
    logic             rd_b_vld_reg;

    // an entry never written reads as zero pointers
    always_comb begin
        vld_next = vld_reg;
        if (wr_req.en) begin
            vld_next[wr_req.addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            mem[wr_req.addr] <= wr_req.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_req.en) begin
            rd_a_reg     <= mem[rd_req.addr_a];
            rd_b_reg     <= mem[rd_req.addr_b];
            rd_a_vld_reg <= vld_reg[rd_req.addr_a];
            rd_b_vld_reg <= vld_reg[rd_req.addr_b];
        end
    end

    assign rd_a = rd_a_vld_reg ? rd_a_reg : '0;
    assign rd_b = rd_b_vld_reg ? rd_b_reg : '0;

endmodule
